### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CFG_W        = 5;
  localparam int KEY_W        = 32;
  localparam int DATA_W       = 32;
  // Width used to compare occupancy with the capacity limit (CAPACITY <= 255).
  localparam int EXT_W        = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

endpackage

### rtl/lkvc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_lookup
// Parallel tag compare, LRU pick and free-slot pick over all entries.
// ----------------------------------------------------------------------------
module lkvc_lookup
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int RANK_W   = 4,
  parameter int OCC_W    = 5
) (
  input  logic [CAPACITY-1:0] valid_i,
  input  logic [KEY_W-1:0]    key_i [CAPACITY],
  input  logic [RANK_W-1:0]   rank_i [CAPACITY],
  input  logic [OCC_W-1:0]    occ_i,
  input  logic [KEY_W-1:0]    req_key_i,
  output logic [CAPACITY-1:0] match_oh_o,
  output logic [CAPACITY-1:0] lru_oh_o,
  output logic [CAPACITY-1:0] free_oh_o
);

  logic [CAPACITY-1:0] match_raw;
  logic [CAPACITY-1:0] free_raw;
  logic [OCC_W-1:0]    occ_last;

  assign occ_last = occ_i - 1'b1;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_raw[i] = valid_i[i] && (key_i[i] == req_key_i);
      // valid ranks are a permutation of 0..occ-1, so the oldest has occ-1
      lru_oh_o[i]  = valid_i[i] && (OCC_W'(rank_i[i]) == occ_last);
    end
  end

  assign free_raw   = ~valid_i;
  // lowest set bit
  assign match_oh_o = match_raw & (~match_raw + CAPACITY'(1));
  assign free_oh_o  = free_raw & (~free_raw + CAPACITY'(1));

endmodule

### rtl/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// Result path: a request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while out_stall does not hold a pending result; the lookup
// and recency update are written as a request leaves the input register, so the next request sees the updated entries.
// Reset (rst_n low, synchronous): all entries invalid, ranks and occupancy zero,
// capacity limit 16. No clearing pass; the block takes requests right away.
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with per-entry LRU ranks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_evicted,
  output logic signed [KEY_W-1:0]  out_evicted_key,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_capacity_in_use
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W  = $clog2(CAPACITY + 1);

  // entry storage
  logic [CAPACITY-1:0] valid_r;
  logic [KEY_W-1:0]    key_r  [CAPACITY];
  logic [DATA_W-1:0]   data_r [CAPACITY];
  logic [RANK_W-1:0]   rank_r [CAPACITY];
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [CFG_W-1:0]    cap_r;

  // input register
  logic                req_vld_r, req_vld_nxt;
  logic                req_type_r;
  logic [KEY_W-1:0]    req_key_r;
  logic [DATA_W-1:0]   req_value_r;

  // result register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [DATA_W-1:0]   out_read_value_r;
  logic                out_evicted_r;
  logic [KEY_W-1:0]    out_evicted_key_r;

  logic advance, in_fire, do_req;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = req_vld_r && !advance;
  assign in_fire   = in_valid && !in_stall;
  assign do_req    = req_vld_r && advance;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // lookup
  // --------------------------------------------------------------------------
  logic [CAPACITY-1:0] match_oh, lru_oh, free_oh, tgt_oh;

  lkvc_lookup #(
    .CAPACITY (CAPACITY),
    .RANK_W   (RANK_W),
    .OCC_W    (OCC_W)
  ) u_lookup (
    .valid_i    (valid_r),
    .key_i      (key_r),
    .rank_i     (rank_r),
    .occ_i      (occ_r),
    .req_key_i  (req_key_r),
    .match_oh_o (match_oh),
    .lru_oh_o   (lru_oh),
    .free_oh_o  (free_oh)
  );

  logic              hit, is_put, full, do_evict, do_insert, touch;
  logic [EXT_W-1:0]  cap_ext, eff_cap;
  logic [RANK_W-1:0] tgt_rank;
  logic [OCC_W-1:0]  ref_rank;
  logic [DATA_W-1:0] hit_data;
  logic [KEY_W-1:0]  lru_key;

  assign hit     = |match_oh;
  assign is_put  = (req_type_r == REQ_PUT);
  assign cap_ext = EXT_W'(cap_r);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EXT_W'(1);
    end else if (cap_ext > EXT_W'(CAPACITY)) begin
      eff_cap = EXT_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = (EXT_W'(occ_r) >= eff_cap) || (&valid_r);
  assign do_evict  = is_put && !hit && full && (|valid_r);
  assign do_insert = is_put && !hit && !do_evict && (|free_oh);
  assign touch     = hit || do_evict || do_insert;

  always_comb begin
    if (hit) begin
      tgt_oh = match_oh;
    end else if (do_evict) begin
      tgt_oh = lru_oh;
    end else if (do_insert) begin
      tgt_oh = free_oh;
    end else begin
      tgt_oh = '0;
    end
  end

  // one-hot selects
  always_comb begin
    tgt_rank = '0;
    hit_data = '0;
    lru_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tgt_oh[i])   tgt_rank = tgt_rank | rank_r[i];
      if (match_oh[i]) hit_data = hit_data | data_r[i];
      if (lru_oh[i])   lru_key  = lru_key | key_r[i];
    end
  end

  // entries ranked younger than ref_rank age by one; a new entry ages all
  assign ref_rank = do_insert ? occ_r : OCC_W'(tgt_rank);
  assign occ_nxt  = (do_req && do_insert) ? occ_r + 1'b1 : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      occ_r <= occ_nxt;
      if (do_req && touch) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tgt_oh[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (OCC_W'(rank_r[i]) < ref_rank)) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
      if (do_req && do_insert) begin
        valid_r <= valid_r | free_oh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_req && is_put) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (tgt_oh[i]) begin
          key_r[i]  <= req_key_r;
          data_r[i] <= req_value_r;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity_in_use;
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_fire) begin
      req_vld_nxt = 1'b1;
    end else if (do_req) begin
      req_vld_nxt = 1'b0;
    end else begin
      req_vld_nxt = req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r  <= in_req_type;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_req) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_req) begin
      out_hit_r         <= hit;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? lru_key : '0;
      if (is_put) begin
        out_read_value_r <= '0;
      end else if (hit) begin
        out_read_value_r <= hit_data;
      end else begin
        out_read_value_r <= READ_MISS;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_r) == int'(occ_r),
    "occupancy differs from number of valid entries")
  `ASSERT_SAME(a_lru_unique, occ_r != '0, $onehot(lru_oh),
    "no single least recent entry while occupied")
  `ASSERT_ALWAYS(a_match_unique, $onehot0(match_oh & valid_r),
    "key matches more than one entry")
  `ASSERT_NEXT(a_insert_grows, do_req && do_insert, occ_r == $past(occ_r) + 1'b1,
    "insert did not grow occupancy")

endmodule
